FILE: rtl/imoe_pkg.sv
// Package for the integer matrix operation engine.
// Holds sizes, operation, kind and config index codes, and the sequencer state type.
// No dependencies.
package imoe_pkg;
	localparam int MaxDim = 8;
	localparam int DataWidth = 32;
	localparam int Cells = MaxDim * MaxDim;
	localparam int AddrW = $clog2(Cells);
	localparam int DimW = $clog2(MaxDim);

	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_START  = 2'd2;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_TRN = 3'd3;
	localparam logic [2:0] OP_NOT = 3'd4;
	localparam logic [2:0] OP_AND = 3'd5;
	localparam logic [2:0] OP_OR  = 3'd6;
	localparam logic [2:0] OP_RSV = 3'd7;

	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_OP   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MRD,
		ST_MACC,
		ST_MWR,
		ST_ERD,
		ST_EOUT
	} state_t;
endpackage

FILE: rtl/integer_matrix_operation_engine.sv
// Top level of the integer matrix operation engine.
// Uses imoe_pkg; holds matrices A and B and a scratch memory for multiply.
//
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata: value[31:0], tuser: kind[1:0]
// m_axis    out  tvalid/tready    tdata: result_value, out_row, out_col, error; tlast
// cfg       in   cfg_we           cfg_index, cfg_data
//
// Loads are accepted only while idle. A start steps each emitted element through a read
// state and an output state; multiply first fills the scratch memory, reading one product per
// cycle from the single read port of A and B. Reset clears control state only;
// the memories hold no reset. A stalled output holds the sequencer.
module integer_matrix_operation_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value[31:0]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // result_value[31:0], out_row[34:32], out_col[37:35], error[38]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	localparam int AW = imoe_pkg::AddrW;
	localparam int DW = imoe_pkg::DataWidth;
	localparam int NW = imoe_pkg::DimW;

	logic [DW-1:0] mem_a [imoe_pkg::Cells];
	logic [DW-1:0] mem_b [imoe_pkg::Cells];
	logic [DW-1:0] mem_s [imoe_pkg::Cells];

	imoe_pkg::state_t state_q, state_d;
	logic [3:0] rows_cfg_q, cols_cfg_q;
	logic [2:0] op_q;
	logic [AW-1:0] a_idx_q, b_idx_q;
	logic [NW:0] rows_q, cols_q;
	logic [NW:0] i_q, j_q, z_q;
	logic halted_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] rd_a, rd_b, rd_s;
	logic rd_v_s1;
	logic [DW-1:0] prod_s2;
	logic prod_v_s2;
	logic out_v_q;
	logic [39:0] out_data_q;
	logic out_last_q;
	logic use_s_q;

	logic [AW-1:0] ra_addr, rb_addr;
	logic rd_en;
	logic accept;

	function automatic logic [NW:0] clamp(input logic [3:0] v);
		if (v == 4'd0) return (NW+1)'(1);
		if ({1'b0, v} > 5'(imoe_pkg::MaxDim)) return (NW+1)'(imoe_pkg::MaxDim);
		return (NW+1)'(v);
	endfunction

	function automatic logic [AW-1:0] flat(input logic [NW:0] r, input logic [NW:0] c,
		input logic [NW:0] w);
		logic [2*NW+2:0] t;
		t = r * w + c;
		return t[AW-1:0];
	endfunction

	assign s_axis_tready = (state_q == imoe_pkg::ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	logic is_trn;
	assign is_trn = (op_q == imoe_pkg::OP_TRN);

	always_comb begin
		ra_addr = '0;
		rb_addr = '0;
		rd_en = 1'b0;
		unique case (state_q)
			imoe_pkg::ST_MRD: begin
				ra_addr = flat(i_q, z_q, cols_q);
				rb_addr = flat(z_q, j_q, cols_q);
				rd_en = 1'b1;
			end
			imoe_pkg::ST_ERD: begin
				ra_addr = is_trn ? flat(j_q, i_q, cols_q) : flat(i_q, j_q, cols_q);
				rb_addr = flat(i_q, j_q, cols_q);
				rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a <= mem_a[ra_addr];
			rd_b <= mem_b[rb_addr];
			rd_s <= mem_s[ra_addr];
		end
		prod_s2 <= rd_a * rd_b;
		if (state_q == imoe_pkg::ST_MWR)
			mem_s[flat(i_q, j_q, cols_q)] <= acc_q;
	end

	logic last_elem;
	logic [DW-1:0] opa, res;
	logic wr_res, err;
	always_comb begin
		opa = use_s_q ? rd_s : rd_a;
		res = opa;
		wr_res = 1'b0;
		err = 1'b0;
		if (!halted_q) begin
			case (op_q)
				imoe_pkg::OP_ADD: begin res = opa + rd_b; wr_res = 1'b1; end
				imoe_pkg::OP_SUB: begin res = opa - rd_b; wr_res = 1'b1; end
				imoe_pkg::OP_MUL: wr_res = 1'b1;
				imoe_pkg::OP_NOT: begin
					if (opa == DW'(1)) begin res = '0; wr_res = 1'b1; end
					else if (opa == '0) begin res = DW'(1); wr_res = 1'b1; end
					else err = 1'b1;
				end
				imoe_pkg::OP_AND: begin
					if (opa == DW'(1) && rd_b == DW'(1)) begin res = DW'(1); wr_res = 1'b1; end
					else if (opa == '0 || rd_b == '0) begin res = '0; wr_res = 1'b1; end
					else err = 1'b1;
				end
				imoe_pkg::OP_OR: begin
					if (opa == DW'(1) || rd_b == DW'(1)) begin res = DW'(1); wr_res = 1'b1; end
					else if (opa == '0 && rd_b == '0) begin res = '0; wr_res = 1'b1; end
					else err = 1'b1;
				end
				default: ;
			endcase
		end
		last_elem = is_trn ? (i_q == cols_q - 1'b1 && j_q == rows_q - 1'b1)
			: (i_q == rows_q - 1'b1 && j_q == cols_q - 1'b1);
	end

	logic out_free;
	assign out_free = !out_v_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imoe_pkg::ST_IDLE:
				if (accept && s_axis_tuser == imoe_pkg::KIND_START) begin
					if (op_q == imoe_pkg::OP_MUL) state_d = imoe_pkg::ST_MRD;
					else if (op_q != imoe_pkg::OP_RSV) state_d = imoe_pkg::ST_ERD;
				end
			imoe_pkg::ST_MRD:
				if (z_q == cols_q - 1'b1) state_d = imoe_pkg::ST_MACC;
			imoe_pkg::ST_MACC:
				if (!rd_v_s1) state_d = imoe_pkg::ST_MWR;
			imoe_pkg::ST_MWR:
				if (i_q == rows_q - 1'b1 && j_q == cols_q - 1'b1) state_d = imoe_pkg::ST_ERD;
				else state_d = imoe_pkg::ST_MRD;
			imoe_pkg::ST_ERD: state_d = imoe_pkg::ST_EOUT;
			imoe_pkg::ST_EOUT:
				if (out_free) state_d = last_elem ? imoe_pkg::ST_IDLE : imoe_pkg::ST_ERD;
			default: state_d = imoe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imoe_pkg::ST_IDLE;
			rows_cfg_q <= 4'd1;
			cols_cfg_q <= 4'd1;
			op_q <= imoe_pkg::OP_ADD;
			a_idx_q <= '0;
			b_idx_q <= '0;
			out_v_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			z_q <= '0;
			halted_q <= 1'b0;
			use_s_q <= 1'b0;
			rows_q <= '0;
			cols_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					imoe_pkg::CFG_ROWS: rows_cfg_q <= cfg_data;
					imoe_pkg::CFG_COLS: cols_cfg_q <= cfg_data;
					imoe_pkg::CFG_OP:   op_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			out_v_q <= (state_q == imoe_pkg::ST_EOUT && out_free) || (out_v_q && !m_axis_tready);
			rd_v_s1 <= (state_q == imoe_pkg::ST_MRD);
			prod_v_s2 <= rd_v_s1;
			unique case (state_q)
				imoe_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (s_axis_tuser)
							imoe_pkg::KIND_LOAD_A: a_idx_q <= a_idx_q + 1'b1;
							imoe_pkg::KIND_LOAD_B: b_idx_q <= b_idx_q + 1'b1;
							imoe_pkg::KIND_START: begin a_idx_q <= '0; b_idx_q <= '0; end
							default: ;
						endcase
					end
					rows_q <= clamp(rows_cfg_q);
					cols_q <= clamp(cols_cfg_q);
					i_q <= '0;
					j_q <= '0;
					z_q <= '0;
					halted_q <= 1'b0;
					use_s_q <= (op_q == imoe_pkg::OP_MUL);
				end
				imoe_pkg::ST_MRD: begin
					if (z_q == cols_q - 1'b1) z_q <= '0;
					else z_q <= z_q + 1'b1;
				end
				imoe_pkg::ST_MACC: z_q <= '0;
				imoe_pkg::ST_MWR: begin
					if (j_q == cols_q - 1'b1) begin
						j_q <= '0;
						i_q <= (i_q == rows_q - 1'b1) ? '0 : i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				imoe_pkg::ST_EOUT: begin
					if (out_free) begin
						if (is_trn) begin
							if (j_q == rows_q - 1'b1) begin j_q <= '0; i_q <= i_q + 1'b1; end
							else j_q <= j_q + 1'b1;
						end else begin
							if (j_q == cols_q - 1'b1) begin
								j_q <= '0; i_q <= i_q + 1'b1; halted_q <= 1'b0;
							end else begin
								j_q <= j_q + 1'b1;
								if (err) halted_q <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == imoe_pkg::ST_MRD && z_q == '0) acc_q <= '0;
		else if (prod_v_s2) acc_q <= acc_q + prod_s2;
		if (accept && s_axis_tuser == imoe_pkg::KIND_LOAD_A) mem_a[a_idx_q] <= s_axis_tdata;
		if (accept && s_axis_tuser == imoe_pkg::KIND_LOAD_B) mem_b[b_idx_q] <= s_axis_tdata;
		if (state_q == imoe_pkg::ST_EOUT && out_free) begin
			if (!is_trn && wr_res) mem_a[flat(i_q, j_q, cols_q)] <= res;
			out_data_q <= {1'b0, err, j_q[NW-1:0], i_q[NW-1:0], is_trn ? rd_a : res};
			out_last_q <= last_elem;
		end
	end
endmodule
